/* sv/fbps_pkg.sv */
// ----------------------------------------------------------------------------
// fbps_pkg: shared types and constants
// Types, constants and helpers for the fan button / PWM / swing controller.
// ----------------------------------------------------------------------------
package fbps_pkg;

	// Button counters
	localparam int COUNT_LIMIT = 10000;
	localparam int CNT_W       = 14;

	// Fan PWM
	localparam int PWM_SLOTS = 10;
	localparam int SLOT_W    = 4;
	// slot threshold = speed*PWM_SLOTS/100 via reciprocal of 100 (2^20 scale)
	localparam int PWM_RECIP = 10486;
	localparam int PWM_MULT  = PWM_SLOTS * PWM_RECIP;
	localparam int PWM_SHIFT = 20;
	localparam int THR_W     = 5;
	localparam int PWM_PROD_W = PWM_SHIFT + THR_W;

	// Swing stepper
	localparam int SWING_DIVIDE = 5;
	localparam int DIV_W        = 3;
	localparam int STEP_TICK    = 1 % SWING_DIVIDE;
	localparam int SWEEP_W      = 10;
	// sweep = 142*angle/100 via reciprocal of 100 (2^24 scale)
	localparam int SWEEP_RECIP  = 167773;
	localparam int SWEEP_MULT   = 142 * SWEEP_RECIP;
	localparam int SWEEP_SHIFT  = 24;
	localparam int SWEEP_PROD_W = 34;

	// Speed
	localparam int SPEED_W     = 7;
	localparam int SPEED_MAX   = 99;
	localparam int SPEED_RESET = 49;

	// Coil patterns
	localparam logic [3:0] COIL_IDLE  = 4'hF;
	localparam logic [3:0] COIL_FWD_A = 4'h1;
	localparam logic [3:0] COIL_FWD_B = 4'h4;
	localparam logic [3:0] COIL_BWD_A = 4'h2;
	localparam logic [3:0] COIL_BWD_B = 4'h8;

	// Configuration registers
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	localparam int STEP_RESET    = 10;
	localparam int ANGLE_RESET   = 120;
	localparam int PRESS_RESET   = 5;
	localparam int LONG_RESET    = 80;
	localparam int RELEASE_RESET = 5;
	localparam int SWEEP_RESET   = (142 * ANGLE_RESET) / 100;

	typedef enum logic [2:0] {
		REG_SPEED_STEP    = 3'd0,
		REG_SWING_ANGLE   = 3'd1,
		REG_PRESS_TICKS   = 3'd2,
		REG_LONG_TICKS    = 3'd3,
		REG_RELEASE_TICKS = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		CLS_RELEASED = 3'b001,
		CLS_PRESS    = 3'b010,
		CLS_LONG     = 3'b100
	} press_class_t;

	typedef enum logic [1:0] {
		MODE_INFO  = 2'd0,
		MODE_FAN   = 2'd1,
		MODE_SWING = 2'd2
	} menu_mode_t;

	typedef struct packed {
		logic [6:0]         speed_step;
		logic [8:0]         swing_angle;
		logic [7:0]         press_ticks;
		logic [CNT_W-1:0]   long_ticks;
		logic [7:0]         release_ticks;
		logic [SWEEP_W-1:0] sweep_full;
		logic [SWEEP_W-1:0] sweep_half;
	} cfg_t;

	typedef struct packed {
		logic fire;
		logic is_long;
	} btn_evt_t;

	typedef struct packed {
		logic op_button_low;
		logic up_button_low;
		logic down_button_low;
	} in_item_t;

	typedef struct packed {
		logic               fan_drive;
		logic [3:0]         coil_pattern;
		logic [1:0]         menu_mode;
		logic               fan_on;
		logic               swing_on;
		logic [SPEED_W-1:0] speed_level;
	} out_item_t;

	typedef struct packed {
		logic               run;
		logic [SWEEP_W-1:0] steps;
		logic [SWEEP_W-1:0] paused;
		logic [3:0]         coils;
	} swing_t;

	// Start resumes the paused count (half a sweep when none is left), stop parks it.
	function automatic swing_t toggle_swing(swing_t cur, logic [SWEEP_W-1:0] half);
		swing_t nxt;
		nxt = cur;
		if (!cur.run) begin
			if (cur.paused == '0) begin
				nxt.paused = half;
			end
			nxt.steps = nxt.paused;
		end else begin
			nxt.paused = cur.steps;
			nxt.steps  = '0;
			nxt.coils  = COIL_IDLE;
		end
		nxt.run = !cur.run;
		return nxt;
	endfunction

	function automatic menu_mode_t next_mode(menu_mode_t m);
		menu_mode_t r;
		case (m)
			MODE_INFO: r = MODE_FAN;
			MODE_FAN:  r = MODE_SWING;
			default:   r = MODE_INFO;
		endcase
		return r;
	endfunction

endpackage

/* sv/fbps_in_if.sv */
// ----------------------------------------------------------------------------
// fbps_in_if: tick request channel
// Valid/ready channel carrying the three active-low button levels.
// ----------------------------------------------------------------------------
interface fbps_in_if;
	logic valid;
	logic ready;
	logic op_button_low;
	logic up_button_low;
	logic down_button_low;

	modport source (
		output valid, op_button_low, up_button_low, down_button_low,
		input  ready
	);
	modport sink (
		input  valid, op_button_low, up_button_low, down_button_low,
		output ready
	);
endinterface

/* sv/fbps_out_if.sv */
// ----------------------------------------------------------------------------
// fbps_out_if: result channel
// Valid/ready channel carrying the controller state after each tick.
// ----------------------------------------------------------------------------
interface fbps_out_if;
	logic                        valid;
	logic                        ready;
	logic                        fan_drive;
	logic [3:0]                  coil_pattern;
	logic [1:0]                  menu_mode;
	logic                        fan_on;
	logic                        swing_on;
	logic [fbps_pkg::SPEED_W-1:0] speed_level;

	modport source (
		output valid, fan_drive, coil_pattern, menu_mode, fan_on, swing_on, speed_level,
		input  ready
	);
	modport sink (
		input  valid, fan_drive, coil_pattern, menu_mode, fan_on, swing_on, speed_level,
		output ready
	);
endinterface

/* sv/fbps_cfg.sv */
// ----------------------------------------------------------------------------
// fbps_cfg: configuration registers
// APB register file plus the registered sweep length derived from the angle.
// ----------------------------------------------------------------------------
module fbps_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fbps_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [fbps_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [fbps_pkg::CFG_DATA_W-1:0]   prdata,
	output fbps_pkg::cfg_t                    cfg
);

	logic [6:0]                       speed_step_q;
	logic [8:0]                       swing_angle_q;
	logic [7:0]                       press_ticks_q;
	logic [fbps_pkg::CNT_W-1:0]       long_ticks_q;
	logic [7:0]                       release_ticks_q;
	logic [fbps_pkg::SWEEP_W-1:0]     sweep_q;
	logic [fbps_pkg::SWEEP_PROD_W-1:0] sweep_prod;
	fbps_pkg::reg_index_t             idx;
	logic                             wr;

	assign idx = fbps_pkg::reg_index_t'(paddr[fbps_pkg::CFG_ADDR_W-1:2]);
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_step_q    <= 7'(fbps_pkg::STEP_RESET);
			swing_angle_q   <= 9'(fbps_pkg::ANGLE_RESET);
			press_ticks_q   <= 8'(fbps_pkg::PRESS_RESET);
			long_ticks_q    <= fbps_pkg::CNT_W'(fbps_pkg::LONG_RESET);
			release_ticks_q <= 8'(fbps_pkg::RELEASE_RESET);
		end else if (wr) begin
			case (idx)
				fbps_pkg::REG_SPEED_STEP:    speed_step_q    <= pwdata[6:0];
				fbps_pkg::REG_SWING_ANGLE:   swing_angle_q   <= pwdata[8:0];
				fbps_pkg::REG_PRESS_TICKS:   press_ticks_q   <= pwdata[7:0];
				fbps_pkg::REG_LONG_TICKS:    long_ticks_q    <= pwdata[fbps_pkg::CNT_W-1:0];
				fbps_pkg::REG_RELEASE_TICKS: release_ticks_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// 142*angle/100 by reciprocal multiply; sweep_q registers it from the stored angle
	assign sweep_prod = fbps_pkg::SWEEP_PROD_W'(swing_angle_q)
		* fbps_pkg::SWEEP_PROD_W'(fbps_pkg::SWEEP_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= fbps_pkg::SWEEP_W'(fbps_pkg::SWEEP_RESET);
		end else begin
			sweep_q <= sweep_prod[fbps_pkg::SWEEP_SHIFT +: fbps_pkg::SWEEP_W];
		end
	end

	always_comb begin
		case (idx)
			fbps_pkg::REG_SPEED_STEP:    prdata = fbps_pkg::CFG_DATA_W'(speed_step_q);
			fbps_pkg::REG_SWING_ANGLE:   prdata = fbps_pkg::CFG_DATA_W'(swing_angle_q);
			fbps_pkg::REG_PRESS_TICKS:   prdata = fbps_pkg::CFG_DATA_W'(press_ticks_q);
			fbps_pkg::REG_LONG_TICKS:    prdata = fbps_pkg::CFG_DATA_W'(long_ticks_q);
			fbps_pkg::REG_RELEASE_TICKS: prdata = fbps_pkg::CFG_DATA_W'(release_ticks_q);
			default:                     prdata = '0;
		endcase
	end

	assign cfg.speed_step    = speed_step_q;
	assign cfg.swing_angle   = swing_angle_q;
	assign cfg.press_ticks   = press_ticks_q;
	assign cfg.long_ticks    = long_ticks_q;
	assign cfg.release_ticks = release_ticks_q;
	assign cfg.sweep_full    = sweep_q;
	assign cfg.sweep_half    = sweep_q >> 1;

endmodule

/* sv/fbps_button.sv */
// ----------------------------------------------------------------------------
// fbps_button: button classifier
// Saturating low/high tick counters; flags a press or long press on release.
// ----------------------------------------------------------------------------
module fbps_button (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 level,
	input  fbps_pkg::cfg_t       cfg,
	output fbps_pkg::btn_evt_t   evt
);

	logic [fbps_pkg::CNT_W-1:0] low_q;
	logic [fbps_pkg::CNT_W-1:0] high_q;
	fbps_pkg::press_class_t     class_q;

	logic [fbps_pkg::CNT_W-1:0] low_d;
	logic [fbps_pkg::CNT_W-1:0] high_d;
	fbps_pkg::press_class_t     class_d;
	fbps_pkg::press_class_t     cls;
	logic                       armed;

	always_comb begin
		armed = low_q > fbps_pkg::CNT_W'(cfg.press_ticks);
		cls   = (low_q > cfg.long_ticks) ? fbps_pkg::CLS_LONG : fbps_pkg::CLS_PRESS;
		evt.fire    = level && armed && (cls != class_q);
		evt.is_long = cls == fbps_pkg::CLS_LONG;

		low_d   = low_q;
		high_d  = high_q;
		class_d = class_q;
		if (!level) begin
			if (low_q < fbps_pkg::CNT_W'(fbps_pkg::COUNT_LIMIT)) begin
				low_d = low_q + 1'b1;
			end
			high_d = '0;
		end else begin
			if (evt.fire) begin
				class_d = cls;
			end
			if (high_q < fbps_pkg::CNT_W'(fbps_pkg::COUNT_LIMIT)) begin
				high_d = high_q + 1'b1;
			end
			// re-arm once the pin has stayed high long enough
			if (high_d > fbps_pkg::CNT_W'(cfg.release_ticks)) begin
				class_d = fbps_pkg::CLS_RELEASED;
				low_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= '0;
			high_q  <= '0;
			class_q <= fbps_pkg::CLS_RELEASED;
		end else if (advance) begin
			low_q   <= low_d;
			high_q  <= high_d;
			class_q <= class_d;
		end
	end

endmodule

/* sv/fbps_core.sv */
// ----------------------------------------------------------------------------
// fbps_core: menu, fan PWM and swing stepper
// Applies the button events of one tick; its state registers are the result.
// ----------------------------------------------------------------------------
module fbps_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  fbps_pkg::btn_evt_t   evt_op,
	input  fbps_pkg::btn_evt_t   evt_up,
	input  fbps_pkg::btn_evt_t   evt_down,
	input  fbps_pkg::cfg_t       cfg,
	output fbps_pkg::out_item_t  result
);

	fbps_pkg::menu_mode_t            mode_q, mode_d;
	logic [fbps_pkg::SPEED_W-1:0]    speed_q, speed_d;
	logic                            power_q, power_d;
	logic                            pin_q, pin_d;
	logic [fbps_pkg::SLOT_W-1:0]     slot_q, slot_d;
	fbps_pkg::swing_t                swing_q, swing_d;
	logic                            dir_q, dir_d;
	logic                            phase_q, phase_d;
	logic [fbps_pkg::DIV_W-1:0]      div_q, div_d;

	logic [fbps_pkg::SPEED_W:0]      speed_sum;
	logic [fbps_pkg::PWM_PROD_W-1:0] pwm_prod;
	logic [fbps_pkg::THR_W-1:0]      pwm_thr;

	always_comb begin
		mode_d  = mode_q;
		speed_d = speed_q;
		power_d = power_q;
		slot_d  = slot_q;
		pin_d   = pin_q;
		swing_d = swing_q;
		dir_d   = dir_q;
		phase_d = phase_q;
		div_d   = div_q;

		// mode button
		if (evt_op.fire) begin
			if (evt_op.is_long) begin
				mode_d = (mode_q == fbps_pkg::MODE_INFO) ? fbps_pkg::next_mode(mode_q)
					: fbps_pkg::MODE_INFO;
			end else if (mode_q == fbps_pkg::MODE_INFO) begin
				power_d = !power_q;
			end else begin
				mode_d = fbps_pkg::next_mode(mode_q);
			end
		end

		// up button, then down button, both in the mode left by the mode button
		speed_sum = {1'b0, speed_d} + {1'b0, cfg.speed_step};
		if (evt_up.fire) begin
			case (mode_d)
				fbps_pkg::MODE_FAN: begin
					speed_d = (speed_sum >= (fbps_pkg::SPEED_W + 1)'(fbps_pkg::SPEED_MAX))
						? fbps_pkg::SPEED_W'(fbps_pkg::SPEED_MAX) : speed_sum[fbps_pkg::SPEED_W-1:0];
				end
				fbps_pkg::MODE_SWING: swing_d = fbps_pkg::toggle_swing(swing_d, cfg.sweep_half);
				default: ;
			endcase
		end
		if (evt_down.fire) begin
			case (mode_d)
				fbps_pkg::MODE_FAN: begin
					if (speed_d > cfg.speed_step) begin
						speed_d = speed_d - cfg.speed_step;
					end
				end
				fbps_pkg::MODE_SWING: swing_d = fbps_pkg::toggle_swing(swing_d, cfg.sweep_half);
				default: ;
			endcase
		end

		// fan PWM, threshold speed*slots/100 by reciprocal multiply
		pwm_prod = fbps_pkg::PWM_PROD_W'(speed_d) * fbps_pkg::PWM_PROD_W'(fbps_pkg::PWM_MULT);
		pwm_thr  = pwm_prod[fbps_pkg::PWM_SHIFT +: fbps_pkg::THR_W];
		if (!power_d) begin
			pin_d = 1'b0;
		end else begin
			slot_d = (slot_q == fbps_pkg::SLOT_W'(fbps_pkg::PWM_SLOTS - 1)) ? '0 : slot_q + 1'b1;
			pin_d  = fbps_pkg::THR_W'(slot_d) <= pwm_thr;
		end

		// swing stepper
		if (swing_d.run) begin
			div_d = (div_q == fbps_pkg::DIV_W'(fbps_pkg::SWING_DIVIDE - 1)) ? '0 : div_q + 1'b1;
			if (div_d == fbps_pkg::DIV_W'(fbps_pkg::STEP_TICK) && swing_d.steps != '0) begin
				if (!dir_q) begin
					swing_d.coils = phase_q ? fbps_pkg::COIL_FWD_B : fbps_pkg::COIL_FWD_A;
				end else begin
					swing_d.coils = phase_q ? fbps_pkg::COIL_BWD_B : fbps_pkg::COIL_BWD_A;
				end
				phase_d       = !phase_q;
				swing_d.steps = swing_d.steps - 1'b1;
				if (swing_d.steps == '0) begin
					dir_d         = !dir_q;
					swing_d.steps = cfg.sweep_full;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= fbps_pkg::MODE_INFO;
			speed_q <= fbps_pkg::SPEED_W'(fbps_pkg::SPEED_RESET);
			power_q <= 1'b0;
			pin_q   <= 1'b0;
			slot_q  <= '0;
			swing_q <= '{run: 1'b0, steps: '0, paused: '0, coils: fbps_pkg::COIL_IDLE};
			dir_q   <= 1'b0;
			phase_q <= 1'b0;
			div_q   <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			speed_q <= speed_d;
			power_q <= power_d;
			pin_q   <= pin_d;
			slot_q  <= slot_d;
			swing_q <= swing_d;
			dir_q   <= dir_d;
			phase_q <= phase_d;
			div_q   <= div_d;
		end
	end

	assign result.fan_drive    = pin_q;
	assign result.coil_pattern = swing_q.coils;
	assign result.menu_mode    = mode_q;
	assign result.fan_on       = power_q;
	assign result.swing_on     = swing_q.run;
	assign result.speed_level  = speed_q;

endmodule

/* sv/fan_button_pwm_swing_controller_top.sv */
// ----------------------------------------------------------------------------
// fan_button_pwm_swing_controller_top: fan controller top level
// Button scan, fan PWM and swing stepper, one 10 ms tick per request.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch carries one tick request: the three active-low button pin levels.
//  - out_ch returns one result per tick: fan pin, coil pattern, menu mode,
//    fan power, swing state and speed setting after that tick.
//  - APB port holds speed_step, swing_angle, press_ticks, long_ticks and
//    release_ticks at byte addresses 0, 4, 8, 12, 16. Write only while idle.
//  - Path: a request waits in the input register, then one pass of logic moves
//    it into the state/result registers once the result slot is free.
//  - Throughput: one request per clock unless out_ch stalls. The input register
//    takes a new request while the previous result waits for out_ch.ready.
//  - A stalled receiver holds the result; the input register then fills and
//    in_ch.ready drops until the result is taken.
//  - Reset (arst_n low) clears all counters and state, restores the register
//    defaults and empties both stages. No clearing pass is needed.
// ----------------------------------------------------------------------------
module fan_button_pwm_swing_controller_top (
	input  logic                            clk,
	input  logic                            arst_n,
	fbps_in_if.sink                         in_ch,
	fbps_out_if.source                      out_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fbps_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [fbps_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [fbps_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);

	fbps_pkg::cfg_t      cfg;
	fbps_pkg::in_item_t  item_s1;
	logic                valid_s1;
	logic                valid_s2;
	logic                advance;
	fbps_pkg::btn_evt_t  evt_op, evt_up, evt_down;
	fbps_pkg::out_item_t result;

	assign pready = 1'b1;

	// the result slot frees when empty or when the receiver takes it
	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= '{op_button_low:   in_ch.op_button_low,
			             up_button_low:   in_ch.up_button_low,
			             down_button_low: in_ch.down_button_low};
		end
	end

	// result valid; the payload is the core's state, which moves only on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	fbps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// one classifier per button: mode, up, down
	fbps_button u_scan_op (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.level   (item_s1.op_button_low),
		.cfg     (cfg),
		.evt     (evt_op)
	);

	fbps_button u_scan_up (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.level   (item_s1.up_button_low),
		.cfg     (cfg),
		.evt     (evt_up)
	);

	fbps_button u_scan_dn (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.level   (item_s1.down_button_low),
		.cfg     (cfg),
		.evt     (evt_down)
	);

	// menu, fan PWM, stepper; events apply in mode, up, down order
	fbps_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.evt_op   (evt_op),
		.evt_up   (evt_up),
		.evt_down (evt_down),
		.cfg      (cfg),
		.result   (result)
	);

	assign out_ch.valid        = valid_s2;
	assign out_ch.fan_drive    = result.fan_drive;
	assign out_ch.coil_pattern = result.coil_pattern;
	assign out_ch.menu_mode    = result.menu_mode;
	assign out_ch.fan_on       = result.fan_on;
	assign out_ch.swing_on     = result.swing_on;
	assign out_ch.speed_level  = result.speed_level;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: fan button / PWM / swing controller check
// Drives button ticks through the request channel and compares every result
// with a cycle-free model of the scan, PWM and stepper logic. Runs several
// register settings, including the extremes, under varied back-pressure.
// ----------------------------------------------------------------------------
module testbench;

	// Button slots in scan order
	localparam int SLOT_MODE = 0;
	localparam int SLOT_UP   = 1;
	localparam int SLOT_DN   = 2;

	// Pin level masks, bit 2 mode, bit 1 up, bit 0 down (same order as in_item_t)
	localparam bit [2:0] PRESS_MODE = 3'b100;
	localparam bit [2:0] PRESS_UP   = 3'b010;
	localparam bit [2:0] PRESS_DOWN = 3'b001;
	localparam bit [2:0] PRESS_ALL  = 3'b111;
	localparam bit [2:0] PINS_IDLE  = 3'b111;

	localparam int MAX_REPORTS    = 10;
	localparam int DRAIN_SLACK    = 4;     // slack after the last expected result is back
	localparam int WATCHDOG_LIMIT = 5000;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks controller state per accepted tick and holds the
	// expected result of every tick still in flight.
	// ------------------------------------------------------------------------
	class fan_state_scoreboard;
		int unsigned            speed_step, swing_angle, press_ticks, long_ticks, release_ticks;
		int unsigned            low_cnt[3];
		int unsigned            high_cnt[3];
		fbps_pkg::press_class_t btn_class[3];
		fbps_pkg::menu_mode_t   mode;
		int unsigned            speed, pwm_slot, steps_left, paused_steps, tick_div;
		bit                     fan_power, fan_pin, swing_run, sweep_back, phase_b;
		logic [3:0]             coils;
		fbps_pkg::out_item_t    expected_states[$];
		int                     failures;

		function new();
			speed_step    = fbps_pkg::STEP_RESET;
			swing_angle   = fbps_pkg::ANGLE_RESET;
			press_ticks   = fbps_pkg::PRESS_RESET;
			long_ticks    = fbps_pkg::LONG_RESET;
			release_ticks = fbps_pkg::RELEASE_RESET;
			for (int i = 0; i < 3; i++) begin
				low_cnt[i]   = 0;
				high_cnt[i]  = 0;
				btn_class[i] = fbps_pkg::CLS_RELEASED;
			end
			mode         = fbps_pkg::MODE_INFO;
			speed        = fbps_pkg::SPEED_RESET;
			pwm_slot     = 0;
			steps_left   = 0;
			paused_steps = 0;
			tick_div     = 0;
			fan_power    = 0;
			fan_pin      = 0;
			swing_run    = 0;
			sweep_back   = 0;
			phase_b      = 0;
			coils        = fbps_pkg::COIL_IDLE;
			failures     = 0;
		endfunction

		function void write_reg(fbps_pkg::reg_index_t idx, logic [31:0] value);
			case (idx)
				fbps_pkg::REG_SPEED_STEP:    speed_step    = value[6:0];
				fbps_pkg::REG_SWING_ANGLE:   swing_angle   = value[8:0];
				fbps_pkg::REG_PRESS_TICKS:   press_ticks   = value[7:0];
				fbps_pkg::REG_LONG_TICKS:    long_ticks    = value[13:0];
				fbps_pkg::REG_RELEASE_TICKS: release_ticks = value[7:0];
				default: ;
			endcase
		endfunction

		function int unsigned sweep_len();
			return (142 * swing_angle) / 100;
		endfunction

		function void flip_swing();
			if (!swing_run) begin
				if (paused_steps == 0) paused_steps = sweep_len() / 2;
				steps_left = paused_steps;
			end else begin
				paused_steps = steps_left;
				steps_left   = 0;
				coils        = fbps_pkg::COIL_IDLE;
			end
			swing_run = !swing_run;
		endfunction

		function void act(int btn, fbps_pkg::press_class_t c);
			int unsigned sum;
			case (btn)
				SLOT_MODE: begin
					if (c == fbps_pkg::CLS_PRESS) begin
						if (mode == fbps_pkg::MODE_INFO) fan_power = !fan_power;
						else mode = (mode == fbps_pkg::MODE_SWING) ? fbps_pkg::MODE_INFO
							: fbps_pkg::menu_mode_t'(mode + 1);
					end else if (c == fbps_pkg::CLS_LONG) begin
						if (mode == fbps_pkg::MODE_INFO) mode = fbps_pkg::MODE_FAN;
						else mode = fbps_pkg::MODE_INFO;
					end
				end
				SLOT_UP: begin
					if (mode == fbps_pkg::MODE_FAN) begin
						sum   = speed + speed_step;
						speed = (sum >= fbps_pkg::SPEED_MAX) ? fbps_pkg::SPEED_MAX : sum;
					end else if (mode == fbps_pkg::MODE_SWING) begin
						flip_swing();
					end
				end
				default: begin
					if (mode == fbps_pkg::MODE_FAN) begin
						if (speed > speed_step) speed -= speed_step;
					end else if (mode == fbps_pkg::MODE_SWING) begin
						flip_swing();
					end
				end
			endcase
		endfunction

		function void scan_button(int btn, bit level);
			fbps_pkg::press_class_t c;
			if (!level) begin
				if (low_cnt[btn] < fbps_pkg::COUNT_LIMIT) low_cnt[btn]++;
				high_cnt[btn] = 0;
			end else begin
				if (low_cnt[btn] > press_ticks) begin
					c = (low_cnt[btn] > long_ticks) ? fbps_pkg::CLS_LONG : fbps_pkg::CLS_PRESS;
					if (c != btn_class[btn]) begin
						btn_class[btn] = c;
						act(btn, c);
					end
				end
				if (high_cnt[btn] < fbps_pkg::COUNT_LIMIT) high_cnt[btn]++;
				if (high_cnt[btn] > release_ticks) begin
					btn_class[btn] = fbps_pkg::CLS_RELEASED;
					low_cnt[btn]   = 0;
				end
			end
		endfunction

		function void run_pwm();
			if (!fan_power) begin
				fan_pin = 0;
			end else begin
				pwm_slot = (pwm_slot + 1) % fbps_pkg::PWM_SLOTS;
				fan_pin  = (pwm_slot <= (speed * fbps_pkg::PWM_SLOTS) / 100);
			end
		endfunction

		function void run_stepper();
			if (swing_run) begin
				tick_div = (tick_div + 1) % fbps_pkg::SWING_DIVIDE;
				if (tick_div == (1 % fbps_pkg::SWING_DIVIDE) && steps_left != 0) begin
					if (sweep_back) coils = phase_b ? fbps_pkg::COIL_BWD_B : fbps_pkg::COIL_BWD_A;
					else coils = phase_b ? fbps_pkg::COIL_FWD_B : fbps_pkg::COIL_FWD_A;
					phase_b = !phase_b;
					steps_left--;
					if (steps_left == 0) begin
						sweep_back = !sweep_back;
						steps_left = sweep_len();
					end
				end
			end
		endfunction

		function void note_tick(fbps_pkg::in_item_t it);
			fbps_pkg::out_item_t st;
			scan_button(SLOT_MODE, it.op_button_low);
			scan_button(SLOT_UP, it.up_button_low);
			scan_button(SLOT_DN, it.down_button_low);
			run_pwm();
			run_stepper();
			st.fan_drive    = fan_pin;
			st.coil_pattern = coils;
			st.menu_mode    = mode;
			st.fan_on       = fan_power;
			st.swing_on     = swing_run;
			st.speed_level  = fbps_pkg::SPEED_W'(speed);
			expected_states.push_back(st);
		endfunction

		function string show(fbps_pkg::out_item_t s);
			return $sformatf("fan_drive %0d coils %h mode %0d fan_on %0d swing_on %0d speed %0d",
				s.fan_drive, s.coil_pattern, s.menu_mode, s.fan_on, s.swing_on,
				s.speed_level);
		endfunction

		function void check_state(fbps_pkg::out_item_t got);
			fbps_pkg::out_item_t want;
			if (expected_states.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS) $display("unexpected result: %s", show(got));
				return;
			end
			want = expected_states.pop_front();
			if (got.fan_drive !== want.fan_drive || got.coil_pattern !== want.coil_pattern ||
					got.menu_mode !== want.menu_mode || got.fan_on !== want.fan_on ||
					got.swing_on !== want.swing_on || got.speed_level !== want.speed_level) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$display("result mismatch at %0t", $realtime);
					$display("  expected: %s", show(want));
					$display("  actual:   %s", show(got));
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels and the block itself
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [fbps_pkg::CFG_ADDR_W-1:0] paddr;
	logic [fbps_pkg::CFG_DATA_W-1:0] pwdata;
	logic [fbps_pkg::CFG_DATA_W-1:0] prdata;
	logic pready;

	fbps_in_if  in_ch ();
	fbps_out_if out_ch ();

	fan_button_pwm_swing_controller_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	fan_state_scoreboard sb = new();

	int src_idle_pct   = 0;   // chance per cycle that the sender holds off
	int sink_stall_pct = 0;   // chance per cycle that the receiver stalls
	int ticks_sent     = 0;
	int idle_cycles    = 0;

	// ------------------------------------------------------------------------
	// Receiver: random ready, checks every accepted result
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		fbps_pkg::out_item_t seen;
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			seen.fan_drive    = out_ch.fan_drive;
			seen.coil_pattern = out_ch.coil_pattern;
			seen.menu_mode    = out_ch.menu_mode;
			seen.fan_on       = out_ch.fan_on;
			seen.swing_on     = out_ch.swing_on;
			seen.speed_level  = out_ch.speed_level;
			sb.check_state(seen);
		end
		out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Watchdog: any handshake on either channel restarts the count
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("fan_button_pwm_swing_controller_top test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Drivers. Every task starts and ends just after a rising edge.
	// ------------------------------------------------------------------------

	// APB write: setup cycle, then access; left selected so back-to-back
	// writes never lower and raise psel in the same step.
	task automatic apb_write(fbps_pkg::reg_index_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.write_reg(idx, value);
	endtask

	// Only called with the block drained
	task automatic apply_setting(int step, int angle, int press, int long_t, int rel);
		apb_write(fbps_pkg::REG_SPEED_STEP, step);
		apb_write(fbps_pkg::REG_SWING_ANGLE, angle);
		apb_write(fbps_pkg::REG_PRESS_TICKS, press);
		apb_write(fbps_pkg::REG_LONG_TICKS, long_t);
		apb_write(fbps_pkg::REG_RELEASE_TICKS, rel);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// One tick request; valid stays high into the next request when no gap is drawn
	task automatic present_tick(bit [2:0] levels);
		fbps_pkg::in_item_t it;
		it = fbps_pkg::in_item_t'(levels);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.op_button_low   <= it.op_button_low;
		in_ch.up_button_low   <= it.up_button_low;
		in_ch.down_button_low <= it.down_button_low;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_tick(it);
		ticks_sent++;
	endtask

	// Sender goes quiet until every expected result has come back
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (sb.expected_states.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Hold the masked buttons low for some ticks, then release all of them
	task automatic gesture(bit [2:0] mask, int hold, int rest);
		repeat (hold) present_tick(~mask);
		repeat (rest) present_tick(PINS_IDLE);
	endtask

	// Low time: mostly a plain press, some too short, some long presses
	function automatic int random_hold();
		int r, lo, hi;
		r  = $urandom_range(9);
		lo = sb.press_ticks + 1;
		if (r < 2) return $urandom_range(1, (sb.press_ticks > 0) ? sb.press_ticks : 1);
		if (r < 8 || sb.long_ticks > 400) begin
			hi = (sb.long_ticks > lo) ? sb.long_ticks : lo;
			if (hi > lo + 30) hi = lo + 30;
			return $urandom_range(lo, hi);
		end
		return sb.long_ticks + 1 + $urandom_range(4);
	endfunction

	// High time: usually long enough to re-arm, sometimes cut short
	function automatic int random_rest();
		if ($urandom_range(9) < 2) return $urandom_range(0, sb.release_ticks);
		return sb.release_ticks + 1 + $urandom_range(3);
	endfunction

	task automatic random_gesture();
		int r;
		bit [2:0] mask;
		r = $urandom_range(9);
		if (r == 0) begin
			// pin noise, no shape
			repeat ($urandom_range(1, 8)) present_tick(3'($urandom_range(7)));
		end else begin
			if (r < 3) begin
				mask = 3'($urandom_range(1, 7));
			end else begin
				case ($urandom_range(3))
					0, 1: mask = PRESS_MODE;
					2:    mask = PRESS_UP;
					default: mask = PRESS_DOWN;
				endcase
			end
			gesture(mask, random_hold(), random_rest());
		end
	endtask

	// Steer the menu with clean presses; needs press_ticks < long_ticks
	task automatic go_to_mode(fbps_pkg::menu_mode_t target);
		while (sb.mode != target) begin
			if (sb.mode == fbps_pkg::MODE_INFO)
				gesture(PRESS_MODE, sb.long_ticks + 1, sb.release_ticks + 1);
			else
				gesture(PRESS_MODE, sb.press_ticks + 1, sb.release_ticks + 1);
		end
	endtask

	// Random gestures for about n ticks; one full drain early on
	task automatic run_phase(int n);
		int start, count;
		start = ticks_sent;
		count = 0;
		while (ticks_sent - start < n) begin
			if (count == 6) wait_drained();
			random_gesture();
			count++;
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n                = 1'b0;
		in_ch.valid           = 1'b0;
		in_ch.op_button_low   = 1'b1;
		in_ch.up_button_low   = 1'b1;
		in_ch.down_button_low = 1'b1;
		out_ch.ready          = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fast thresholds so one low tick is a press and two a long
		// press, and a button re-arms on its first high tick.
		apply_setting(15, 20, 0, 1, 0);
		gesture(PRESS_MODE, 1, 1);   // info: fan power on
		gesture(PRESS_MODE, 2, 1);   // info long: fan speed menu
		gesture(PRESS_UP, 1, 1);     // speed up
		gesture(PRESS_DOWN, 2, 1);   // long down steps the speed too
		gesture(PRESS_MODE, 1, 1);   // fan menu: on to swing menu
		gesture(PRESS_UP, 1, 6);     // swing on, coils start stepping
		gesture(PRESS_DOWN, 1, 1);   // swing off, coils idle
		gesture(PRESS_ALL, 2, 1);    // all at once: long mode press goes home
		wait_drained();

		// Reset values, sender gaps
		apply_setting(fbps_pkg::STEP_RESET, fbps_pkg::ANGLE_RESET, fbps_pkg::PRESS_RESET,
			fbps_pkg::LONG_RESET, fbps_pkg::RELEASE_RESET);
		src_idle_pct = 77;
		run_phase(180);

		// Smallest nonzero values, receiver stalls; angle 1 gives a zero half sweep
		apply_setting(1, 1, 1, 3, 1);
		src_idle_pct   = 0;
		sink_stall_pct = 77;
		run_phase(170);

		// Widest step and angle, zero thresholds: every release is a long press
		apply_setting(127, 511, 0, 0, 0);
		src_idle_pct   = 33;
		sink_stall_pct = 33;
		run_phase(170);

		// Zero step and zero angle, no idling; force both through the menu first
		apply_setting(0, 0, 2, 6, 2);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		go_to_mode(fbps_pkg::MODE_FAN);
		gesture(PRESS_UP, 3, 3);
		gesture(PRESS_DOWN, 3, 3);
		go_to_mode(fbps_pkg::MODE_SWING);
		gesture(PRESS_UP, 3, 12);
		gesture(PRESS_DOWN, 3, 3);
		run_phase(140);

		// Mid-range setting with a full 360 degree sweep
		apply_setting(33, 360, 3, 10, 3);
		src_idle_pct   = 33;
		sink_stall_pct = 33;
		run_phase(140);

		// All three held together well past the long threshold
		apply_setting(99, 7, 20, 40, 20);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		gesture(PRESS_ALL, 45, 25);

		// long_ticks at its top value: every release reads as a plain press
		wait_drained();
		apply_setting(50, 300, 30, 16383, 10);
		sink_stall_pct = 77;
		gesture(PRESS_MODE, 40, 15);
		run_phase(140);

		wait_drained();
		if (sb.failures == 0 && sb.expected_states.size() == 0) begin
			$display("fan_button_pwm_swing_controller_top test passed");
		end else begin
			$display("fan_button_pwm_swing_controller_top test failed");
		end
		$finish;
	end

endmodule
